[hdl/frp_pkg.sv]
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants for the FASTA record parser
// Parse phase codes, result kind codes, character constants and the
// result struct passed from the step logic to the output register.
// ----------------------------------------------------------------------------
package frp_pkg;

   localparam int ByteW  = 8;
   localparam int KindW  = 2;
   localparam int PhaseW = 2;

   // parse phase codes
   localparam logic [PhaseW-1:0] PH_SEEK = 2'd0;
   localparam logic [PhaseW-1:0] PH_NAME = 2'd1;
   localparam logic [PhaseW-1:0] PH_SKIP = 2'd2;
   localparam logic [PhaseW-1:0] PH_SEQ  = 2'd3;

   // result kind codes
   localparam logic [KindW-1:0] KIND_NAME  = 2'd0;
   localparam logic [KindW-1:0] KIND_SEQ   = 2'd1;
   localparam logic [KindW-1:0] KIND_DONE  = 2'd2;
   localparam logic [KindW-1:0] KIND_TRUNC = 2'd3;

   // characters
   localparam logic [ByteW-1:0] CH_GT    = 8'h3E; // '>'
   localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B; // ';'
   localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
   localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
   localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
   localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
   localparam logic [ByteW-1:0] CH_UP_A  = 8'h41; // 'A'
   localparam logic [ByteW-1:0] CH_LO_A  = 8'h61; // 'a'
   localparam logic [ByteW-1:0] CH_LO_C  = 8'h63;
   localparam logic [ByteW-1:0] CH_LO_G  = 8'h67;
   localparam logic [ByteW-1:0] CH_LO_T  = 8'h74;
   localparam logic [ByteW-1:0] CASE_OFS = CH_LO_A - CH_UP_A;

   typedef struct packed {
      logic             valid;
      logic [KindW-1:0] kind;
      logic [ByteW-1:0] data;
   } result_type;

endpackage

[hdl/frp_step.sv]
// ----------------------------------------------------------------------------
// frp_step: per-byte parse logic
// Given the current phase and comment flag plus one request, computes the
// next phase, the next comment flag and the (optional) result.
// ----------------------------------------------------------------------------
module frp_step (
   input  logic [frp_pkg::PhaseW-1:0] phase,
   input  logic                       in_comment,
   input  logic [frp_pkg::ByteW-1:0]  text_byte,
   input  logic                       end_of_stream,
   output logic [frp_pkg::PhaseW-1:0] phase_next,
   output logic                       in_comment_next,
   output frp_pkg::result_type        result
);
   import frp_pkg::*;

   logic is_eol;
   logic is_ws;
   logic is_lower_base;
   logic [ByteW-1:0] seq_data;

   assign is_eol        = (text_byte == CH_LF) || (text_byte == CH_CR);
   assign is_ws         = is_eol || (text_byte == CH_SPACE) || (text_byte == CH_TAB);
   assign is_lower_base = (text_byte == CH_LO_A) || (text_byte == CH_LO_C) ||
                          (text_byte == CH_LO_G) || (text_byte == CH_LO_T);
   assign seq_data      = is_lower_base ? (text_byte - CASE_OFS) : text_byte;

   always_comb begin
      phase_next      = phase;
      in_comment_next = in_comment;
      result          = '{valid: 1'b0, kind: KIND_NAME, data: '0};

      if (end_of_stream) begin
         phase_next      = PH_SEEK;
         in_comment_next = 1'b0;
         if (phase == PH_SEQ) begin
            result = '{valid: 1'b1, kind: KIND_DONE, data: '0};
         end else if (phase == PH_NAME || phase == PH_SKIP) begin
            result = '{valid: 1'b1, kind: KIND_TRUNC, data: '0};
         end
      end else begin
         unique case (phase)
            PH_SEEK: begin
               if (text_byte == CH_GT) phase_next = PH_NAME;
            end
            PH_NAME: begin
               if (is_eol) begin
                  phase_next      = PH_SKIP;
                  in_comment_next = 1'b0;
               end else begin
                  result = '{valid: 1'b1, kind: KIND_NAME, data: text_byte};
               end
            end
            PH_SKIP, PH_SEQ: begin
               if (phase == PH_SKIP && is_eol) begin
                  in_comment_next = 1'b0;
               end else if (phase == PH_SKIP && text_byte == CH_SEMI) begin
                  in_comment_next = 1'b1;
               end else if (phase == PH_SKIP && in_comment) begin
                  // rest of a comment line is dropped
               end else if (text_byte == CH_GT) begin
                  // record ends (possibly with an empty sequence)
                  phase_next = PH_NAME;
                  result     = '{valid: 1'b1, kind: KIND_DONE, data: '0};
               end else begin
                  phase_next = PH_SEQ;
                  if (!is_ws) begin
                     result = '{valid: 1'b1, kind: KIND_SEQ, data: seq_data};
                  end
               end
            end
            default: begin
               phase_next = PH_SEEK;
            end
         endcase
      end
   end

endmodule

[hdl/frp_out_reg.sv]
// ----------------------------------------------------------------------------
// frp_out_reg: result register
// Holds one result; loads on every accepted request and drains when the
// consumer takes it.
// ----------------------------------------------------------------------------
module frp_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  frp_pkg::result_type       result,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [frp_pkg::KindW-1:0] rsp_kind,
   output logic [frp_pkg::ByteW-1:0] rsp_out_byte
);
   import frp_pkg::*;

   logic             valid_ff, valid_in;
   logic [KindW-1:0] kind_ff, kind_in;
   logic [ByteW-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = result.valid;
         kind_in  = result.kind;
         data_in  = result.data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = data_ff;

endmodule

[hdl/fasta_record_parser_unit.sv]
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while not stalled; the step logic is a single pass of
//   character compares and a phase update, bounded only by the result register.
// Requests are stalled only while a held result is itself stalled.
// Reset (synchronous, active high) returns to header seek with no comment
//   pending and an empty result register.
// ----------------------------------------------------------------------------
// fasta_record_parser_unit: streaming FASTA record parser
// Takes one text byte (or an end-of-stream marker) per request and emits
// name bytes, normalized sequence bytes, record-complete and truncation
// results.
// ----------------------------------------------------------------------------
module fasta_record_parser_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [frp_pkg::ByteW-1:0] req_text_byte,
   input  logic                      req_end_of_stream,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [frp_pkg::KindW-1:0] rsp_kind,
   output logic [frp_pkg::ByteW-1:0] rsp_out_byte
);
   import frp_pkg::*;

   // parser state
   logic [PhaseW-1:0] phase_ff, phase_in;
   logic              comment_ff, comment_in;

   logic [PhaseW-1:0] step_phase;
   logic              step_comment;
   result_type        step_result;
   logic              accept;

   // The result register frees up in the same cycle its content is taken,
   // so a request is refused only when a result is held and stalled.
   assign req_stall = rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;

   frp_step u_step (
      .phase           (phase_ff),
      .in_comment      (comment_ff),
      .text_byte       (req_text_byte),
      .end_of_stream   (req_end_of_stream),
      .phase_next      (step_phase),
      .in_comment_next (step_comment),
      .result          (step_result)
   );

   // state advances only on an accepted request
   always_comb begin
      phase_in   = accept ? step_phase   : phase_ff;
      comment_in = accept ? step_comment : comment_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEEK;
         comment_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
      end
   end

   // bytes that produce nothing still load the register, clearing valid
   frp_out_reg u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .result       (step_result),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule
